// File: sv/vpba_pkg.sv
// Shared types and constants for the virtual page bitmap allocator.
// Holds the status codes, request codes, controller states and a
// lowest-zero finder. No dependencies.
package vpba_pkg;

  localparam int unsigned VPBA_PAGE_COUNT = 4096;
  localparam int unsigned VPBA_PAGE_SHIFT = 12;
  localparam int unsigned OUT_CNT_W       = 13;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_NO_FREE     = 4'd1,
    ST_BACKING     = 4'd2,
    ST_NULL        = 4'd3,
    ST_MISALIGNED  = 4'd4,
    ST_RANGE       = 4'd5,
    ST_NOT_ALLOC   = 4'd6,
    ST_MAP_MISSING = 4'd7,
    ST_UNMAP_FAIL  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SUM,
    S_WORD,
    S_UPDATE,
    S_RESP
  } state_t;

  // Index of the lowest clear bit; zero when none is clear.
  function automatic logic [4:0] first_zero(input logic [31:0] w);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

// File: sv/virtual_page_bitmap_allocator_unit.sv
// Virtual page bitmap allocator, first fit, over a two-level bitmap held
// in synchronous memories. Depends on vpba_pkg.
//
// Usage:
//   in_*  : one request item per handshake; in_req_type 0 allocates the lowest
//           free page, 1 frees in_address; in_backing_ok and in_unmap_ok carry
//           the outcome of the external frame and page table work.
//   out_* : exactly one result item per request: status, page address,
//           used and free page counts after the request.
//   cfg_* : write of region_base, always ready; write only while idle.
// Flow: an item that reaches the bitmap passes check, summary read, bitmap read,
//   update and load into the result register; a free rejected by the address
//   checks or an allocate with no free page goes from check straight to the load.
//   One item is in work at a time and the block returns to idle after each load,
//   so no new item is taken before the last is loaded; the pace is set by the two
//   dependent memory reads (summary word, then bitmap word) and the write back.
// Reset: a clearing pass writes every bitmap and summary word, one word a cycle;
//   no item is accepted until it ends.
// Stall: a result waits in the output register until out_ready; the next
//   item may be accepted meanwhile, and its result waits for the slot.
module virtual_page_bitmap_allocator_unit
  import vpba_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = VPBA_PAGE_COUNT,
  parameter int unsigned PAGE_SHIFT = VPBA_PAGE_SHIFT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [31:0]          in_address,
  input  logic                 in_backing_ok,
  input  logic                 in_unmap_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_status,
  output logic [31:0]          out_page_address,
  output logic [OUT_CNT_W-1:0] out_used_count,
  output logic [OUT_CNT_W-1:0] out_free_count
);

  localparam int unsigned WORD_COUNT = (PAGE_COUNT + 31) / 32;
  localparam int unsigned SUM_COUNT  = (WORD_COUNT + 31) / 32;
  localparam int unsigned WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned SUM_W      = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;
  localparam int unsigned PIDX_W     = WORD_W + 5;
  localparam int unsigned CNT_W      = $clog2(PAGE_COUNT + 1);
  localparam int unsigned LAST_BITS  = PAGE_COUNT - 32 * (WORD_COUNT - 1);
  localparam int unsigned LAST_WORDS = WORD_COUNT - 32 * (SUM_COUNT - 1);
  localparam logic [31:0] WORD_PAD   = 32'(~((64'd1 << LAST_BITS) - 64'd1));
  localparam logic [31:0] SUM_PAD    = 32'(~((64'd1 << LAST_WORDS) - 64'd1));
  localparam logic [31:0] ALIGN_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [63:0] SPAN       = 64'(PAGE_COUNT) << PAGE_SHIFT;
  localparam logic [CNT_W-1:0] PAGE_TOTAL = CNT_W'(PAGE_COUNT);

  // Bitmap: one bit per page, set when used. Summary: one bit per bitmap
  // word, set when that word is full. Top flags: one per summary word.
  logic [31:0] bmp_mem [WORD_COUNT];
  logic [31:0] sum_mem [SUM_COUNT];

  state_t              state_r, state_nxt;
  logic [WORD_W-1:0]   clr_idx_r;
  logic [31:0]         base_r;
  logic                req_type_r;
  logic [31:0]         addr_r;
  logic                backing_r;
  logic                unmap_r;
  logic [SUM_W-1:0]    sum_idx_r;
  logic [WORD_W-1:0]   word_idx_r;
  logic [4:0]          bit_r;
  logic [SUM_COUNT-1:0] top_full_r;
  logic [CNT_W-1:0]    used_r;
  status_t             res_status_r;
  logic [31:0]         res_addr_r;
  logic [31:0]         bmp_rdata_r;
  logic [31:0]         sum_rdata_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [31:0]         out_addr_r;
  logic [OUT_CNT_W-1:0] out_used_r;
  logic [OUT_CNT_W-1:0] out_free_r;

  logic                is_alloc;
  logic                top_all_full;
  logic [SUM_W-1:0]    top_first;
  logic [63:0]         span_end;
  logic [PIDX_W-1:0]   free_idx;
  status_t             chk_status;
  logic [WORD_W-1:0]   alloc_word;
  logic [4:0]          upd_bit;
  logic [31:0]         bit_mask;
  logic [31:0]         sum_mask;
  logic [31:0]         set_word;
  logic [31:0]         set_sum;
  logic                word_full;
  logic                sum_full;
  logic                page_used;
  logic                do_set;
  logic                do_clear;
  status_t             upd_status;
  logic [31:0]         upd_addr;
  logic                out_free_slot;

  logic                bmp_re;
  logic [WORD_W-1:0]   bmp_raddr;
  logic                bmp_we;
  logic [WORD_W-1:0]   bmp_waddr;
  logic [31:0]         bmp_wdata;
  logic                sum_re;
  logic                sum_we;
  logic [SUM_W-1:0]    sum_waddr;
  logic [31:0]         sum_wdata;

  assign cfg_ready     = 1'b1;
  assign in_ready      = (state_r == S_IDLE);
  assign is_alloc      = (req_type_r == REQ_ALLOC);
  assign out_free_slot = !out_valid_r || out_ready;

  // Lowest summary word that still has a non-full bitmap word.
  always_comb begin
    top_first = '0;
    for (int i = SUM_COUNT - 1; i >= 0; i--) begin
      if (!top_full_r[i]) top_first = SUM_W'(i);
    end
  end
  assign top_all_full = &top_full_r;

  // Request checks
  assign span_end = {32'd0, base_r} + SPAN;
  assign free_idx = PIDX_W'((addr_r - base_r) >> PAGE_SHIFT);

  always_comb begin
    if (is_alloc) begin
      chk_status = top_all_full ? ST_NO_FREE : ST_OK;
    end else begin
      priority if (addr_r == 32'd0)                         chk_status = ST_NULL;
      else if ((addr_r & ALIGN_MASK) != 32'd0)              chk_status = ST_MISALIGNED;
      else if (addr_r < base_r || {32'd0, addr_r} >= span_end) chk_status = ST_RANGE;
      else                                                  chk_status = ST_OK;
    end
  end

  // Read-modify-write of the bitmap and summary words
  assign alloc_word = WORD_W'({sum_idx_r, first_zero(sum_rdata_r)});
  assign upd_bit    = is_alloc ? first_zero(bmp_rdata_r) : bit_r;
  assign bit_mask   = 32'd1 << upd_bit;
  assign sum_mask   = 32'd1 << 5'(word_idx_r);
  assign set_word   = bmp_rdata_r | bit_mask;
  assign set_sum    = sum_rdata_r | sum_mask;
  assign word_full  = &set_word;
  assign sum_full   = &set_sum;
  assign page_used  = |(bmp_rdata_r & bit_mask);
  assign do_set     = is_alloc && backing_r;
  assign do_clear   = !is_alloc && page_used && (!backing_r || unmap_r);

  always_comb begin
    if (is_alloc) begin
      upd_status = backing_r ? ST_OK : ST_BACKING;
    end else begin
      priority if (!page_used) upd_status = ST_NOT_ALLOC;
      else if (!backing_r)     upd_status = ST_MAP_MISSING;
      else if (!unmap_r)       upd_status = ST_UNMAP_FAIL;
      else                     upd_status = ST_OK;
    end
  end

  assign upd_addr = do_set ?
      base_r + 32'(64'({word_idx_r, upd_bit}) << PAGE_SHIFT) : 32'd0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_idx_r == WORD_W'(WORD_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (chk_status != ST_OK) ? S_RESP : S_SUM;
      S_SUM:    state_nxt = S_WORD;
      S_WORD:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_RESP;
      S_RESP:   if (out_free_slot) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // Memory port controls
  always_comb begin
    sum_re    = 1'b0;
    bmp_re    = 1'b0;
    bmp_raddr = is_alloc ? alloc_word : word_idx_r;
    bmp_we    = 1'b0;
    bmp_waddr = word_idx_r;
    bmp_wdata = set_word;
    sum_we    = 1'b0;
    sum_waddr = sum_idx_r;
    sum_wdata = set_sum;
    unique case (state_r)
      S_CLEAR: begin
        bmp_we    = 1'b1;
        bmp_waddr = clr_idx_r;
        bmp_wdata = (32'(clr_idx_r) == WORD_COUNT - 1) ? WORD_PAD : 32'd0;
        sum_we    = (32'(clr_idx_r) < SUM_COUNT);
        sum_waddr = SUM_W'(clr_idx_r);
        sum_wdata = (32'(clr_idx_r) == SUM_COUNT - 1) ? SUM_PAD : 32'd0;
      end
      S_SUM:  sum_re = 1'b1;
      S_WORD: bmp_re = 1'b1;
      S_UPDATE: begin
        if (do_set) begin
          bmp_we = 1'b1;
          sum_we = word_full;
        end else if (do_clear) begin
          bmp_we    = 1'b1;
          bmp_wdata = bmp_rdata_r & ~bit_mask;
          sum_we    = 1'b1;
          sum_wdata = sum_rdata_r & ~sum_mask;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bmp_we) bmp_mem[bmp_waddr] <= bmp_wdata;
    if (bmp_re) bmp_rdata_r <= bmp_mem[bmp_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rdata_r <= sum_mem[sum_idx_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      base_r      <= 32'd0;
      top_full_r  <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) base_r <= cfg_data;
      if (state_r == S_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (state_r == S_UPDATE) begin
        if (do_set) begin
          used_r <= used_r + 1'b1;
          if (word_full && sum_full) top_full_r[sum_idx_r] <= 1'b1;
        end else if (do_clear) begin
          if (used_r != '0) used_r <= used_r - 1'b1;
          top_full_r[sum_idx_r] <= 1'b0;
        end
      end
      if (state_r == S_RESP && out_free_slot) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_type_r <= in_req_type;
      addr_r     <= in_address;
      backing_r  <= in_backing_ok;
      unmap_r    <= in_unmap_ok;
    end
    if (state_r == S_CHECK) begin
      res_status_r <= chk_status;
      res_addr_r   <= 32'd0;
      if (is_alloc) begin
        sum_idx_r <= top_first;
      end else begin
        word_idx_r <= free_idx[PIDX_W-1:5];
        bit_r      <= free_idx[4:0];
        sum_idx_r  <= SUM_W'(free_idx >> 10);
      end
    end
    if (state_r == S_WORD && is_alloc) word_idx_r <= alloc_word;
    if (state_r == S_UPDATE) begin
      res_status_r <= upd_status;
      res_addr_r   <= upd_addr;
    end
    if (state_r == S_RESP && out_free_slot) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_used_r   <= OUT_CNT_W'(used_r);
      out_free_r   <= OUT_CNT_W'(PAGE_TOTAL - used_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_page_address = out_addr_r;
  assign out_used_count   = out_used_r;
  assign out_free_count   = out_free_r;

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= PAGE_TOTAL)
    else $error("used page count exceeds page total");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    (bmp_we || sum_we) |-> (state_r == S_CLEAR || state_r == S_UPDATE))
    else $error("memory written outside clear or update");

  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_UPDATE |=> $stable(used_r))
    else $error("used count changed outside update");

endmodule

// File: bench/vpba_allocation_checker.sv
// Checker for the virtual page bitmap allocator: watches the config, request
// and result channels, predicts each result and compares it field by field.
// Depends on vpba_pkg.
module vpba_allocation_checker
  import vpba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [31:0]          in_address,
  input  logic                 in_backing_ok,
  input  logic                 in_unmap_ok,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [3:0]           out_status,
  input  logic [31:0]          out_page_address,
  input  logic [OUT_CNT_W-1:0] out_used_count,
  input  logic [OUT_CNT_W-1:0] out_free_count,
  output int                   fail_count,
  output int                   open_count
);

  typedef struct packed {
    status_t                status;
    logic [31:0]            page_address;
    logic [OUT_CNT_W-1:0]   used_count;
    logic [OUT_CNT_W-1:0]   free_count;
  } alloc_result_t;

  logic          page_used [VPBA_PAGE_COUNT];
  int unsigned   used_pages;
  logic [31:0]   region_base;
  alloc_result_t pending_results [$];

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  // Update the page map and count for one request and return its result.
  function automatic alloc_result_t predict_page_request(input logic req,
      input logic [31:0] addr, input logic backing, input logic unmap);
    alloc_result_t res;
    logic [63:0]   span_end;
    int unsigned   idx;
    res.status       = ST_OK;
    res.page_address = '0;
    if (req == REQ_ALLOC) begin
      for (idx = 0; idx < VPBA_PAGE_COUNT && page_used[idx]; idx++);
      if (idx >= VPBA_PAGE_COUNT) begin
        res.status = ST_NO_FREE;
      end else if (!backing) begin
        res.status = ST_BACKING;
      end else begin
        page_used[idx]   = 1'b1;
        used_pages++;
        res.page_address = region_base + (idx << VPBA_PAGE_SHIFT);
      end
    end else begin
      span_end = {32'd0, region_base} + (64'(VPBA_PAGE_COUNT) << VPBA_PAGE_SHIFT);
      if (addr == 32'd0) begin
        res.status = ST_NULL;
      end else if (addr[VPBA_PAGE_SHIFT-1:0] != '0) begin
        res.status = ST_MISALIGNED;
      end else if (addr < region_base || {32'd0, addr} >= span_end) begin
        res.status = ST_RANGE;
      end else begin
        idx = (addr - region_base) >> VPBA_PAGE_SHIFT;
        if (!page_used[idx]) begin
          res.status = ST_NOT_ALLOC;
        end else if (!backing) begin
          // mapping already gone: release the page anyway
          page_used[idx] = 1'b0;
          if (used_pages > 0) used_pages--;
          res.status = ST_MAP_MISSING;
        end else if (!unmap) begin
          res.status = ST_UNMAP_FAIL;
        end else begin
          page_used[idx] = 1'b0;
          if (used_pages > 0) used_pages--;
        end
      end
    end
    res.used_count = OUT_CNT_W'(used_pages);
    res.free_count = OUT_CNT_W'(VPBA_PAGE_COUNT - used_pages);
    return res;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
      input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      for (int p = 0; p < VPBA_PAGE_COUNT; p++) page_used[p] = 1'b0;
      used_pages  = 0;
      region_base = '0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) region_base = cfg_data;
      // compare the result before queuing a new request: it is always older
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status 0x%0h",
                   $time, out_status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status != want.status)
            report_field("status", 32'(want.status), 32'(out_status));
          if (out_page_address != want.page_address)
            report_field("page_address", want.page_address, out_page_address);
          if (out_used_count != want.used_count)
            report_field("used_count", 32'(want.used_count), 32'(out_used_count));
          if (out_free_count != want.free_count)
            report_field("free_count", 32'(want.free_count), 32'(out_free_count));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(predict_page_request(in_req_type, in_address,
                                                       in_backing_ok, in_unmap_ok));
    end
    open_count = pending_results.size();
  end

endmodule

// File: bench/virtual_page_bitmap_allocator_unit_test.sv
// Top of the allocator testbench: clock, reset, request and config stimulus,
// result back-pressure and the verdict. Depends on vpba_pkg, the allocator
// and vpba_allocation_checker.
module virtual_page_bitmap_allocator_unit_test;
  import vpba_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          LONG_HOLD   = 300;
  localparam logic [31:0] PAGE_MASK   = (32'd1 << VPBA_PAGE_SHIFT) - 32'd1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_req_type;
  logic [31:0]          in_address;
  logic                 in_backing_ok;
  logic                 in_unmap_ok;
  logic                 out_valid;
  logic                 out_ready;
  logic [3:0]           out_status;
  logic [31:0]          out_page_address;
  logic [OUT_CNT_W-1:0] out_used_count;
  logic [OUT_CNT_W-1:0] out_free_count;
  int                   fail_count;
  int                   open_count;

  bit                   gaps_on;
  bit                   hold_outputs;
  logic [31:0]          current_base;
  int                   quiet_cycles;

  virtual_page_bitmap_allocator_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_address       (in_address),
    .in_backing_ok    (in_backing_ok),
    .in_unmap_ok      (in_unmap_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_used_count   (out_used_count),
    .out_free_count   (out_free_count)
  );

  vpba_allocation_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_address       (in_address),
    .in_backing_ok    (in_backing_ok),
    .in_unmap_ok      (in_unmap_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_used_count   (out_used_count),
    .out_free_count   (out_free_count),
    .fail_count       (fail_count),
    .open_count       (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request item; called and returning at a falling edge.
  task automatic offer_request(input logic req, input logic [31:0] addr,
      input logic backing, input logic unmap);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_address    <= addr;
    in_backing_ok <= backing;
    in_unmap_ok   <= unmap;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_region_base(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    @(negedge clk);
    cfg_valid    <= 1'b0;
    current_base = value;
  endtask

  // Drop valid and wait until every result is back and the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (open_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Mix of allocates, frees near the low pages in use, and stray addresses.
  task automatic random_requests(input int count, input int unsigned hot_span);
    int unsigned pick;
    int unsigned k;
    logic [31:0] addr;
    logic        req;
    logic        backing;
    logic        unmap;
    for (int n = 0; n < count; n++) begin
      pick    = $urandom_range(0, 99);
      addr    = $urandom();
      backing = ($urandom_range(0, 7) != 0);
      unmap   = ($urandom_range(0, 7) != 0);
      req     = REQ_ALLOC;
      if (pick >= 50) begin
        req = REQ_FREE;
        if (pick < 90) begin
          k = (pick < 85) ? $urandom_range(0, hot_span)
                          : $urandom_range(0, VPBA_PAGE_COUNT + 4);
          // round up to a page boundary so unaligned bases still hit pages
          addr = (current_base + (k << VPBA_PAGE_SHIFT) + PAGE_MASK) & ~PAGE_MASK;
        end else if (pick < 95) begin
          addr = addr & ~PAGE_MASK;
        end
      end
      offer_request(req, addr, backing, unmap);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int gap_left;
    out_ready = 1'b0;
    gap_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_outputs) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_outputs = 1'b0;
      end else begin
        if (gap_left == 0 && gaps_on && $urandom_range(0, 4) == 0)
          gap_left = $urandom_range(1, 4);
        if (gap_left > 0) begin
          out_ready <= 1'b0;
          gap_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any handshake.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    in_valid      = 1'b0;
    in_req_type   = REQ_ALLOC;
    in_address    = '0;
    in_backing_ok = 1'b0;
    in_unmap_ok   = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    gaps_on       = 1'b1;
    hold_outputs  = 1'b0;
    current_base  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_region_base(32'h0000_0000);

    // directed: base zero, so page zero sits at the null address
    offer_request(REQ_ALLOC, 32'hFFFF_FFFF, 1'b0, 1'b1);
    offer_request(REQ_ALLOC, 32'h0000_0000, 1'b1, 1'b0);
    offer_request(REQ_ALLOC, 32'h1234_5678, 1'b1, 1'b1);
    offer_request(REQ_ALLOC, 32'h0000_0000, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'h0000_0000, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'h0000_1001, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'h0000_1800, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'h0100_0000, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'hFFFF_F000, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'h00FF_F000, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'h0000_5000, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'h0000_1000, 1'b1, 1'b0);
    offer_request(REQ_FREE,  32'h0000_1000, 1'b0, 1'b0);
    offer_request(REQ_FREE,  32'h0000_1000, 1'b1, 1'b1);
    offer_request(REQ_FREE,  32'h0000_2000, 1'b1, 1'b1);
    offer_request(REQ_ALLOC, 32'h0000_0000, 1'b1, 1'b1);
    drain_results();

    write_region_base(32'h4000_0000);
    hold_outputs = 1'b1;
    offer_request(REQ_FREE, 32'h3FFF_F000, 1'b1, 1'b1);
    random_requests(400, 96);
    drain_results();

    // unaligned base: pages are found by rounding down the offset
    write_region_base(32'h0000_0800);
    random_requests(300, 96);
    drain_results();

    // pages past the first wrap around zero and cannot be freed
    write_region_base(32'hFFFF_F000);
    random_requests(300, 96);
    drain_results();

    write_region_base(32'hFFFF_FFFF);
    random_requests(150, 96);
    drain_results();

    // fill a run of low pages, then probe the top edge
    write_region_base(32'h0010_0000);
    for (int n = 0; n < 180; n++)
      offer_request(REQ_ALLOC, $urandom(), 1'b1, 1'($urandom_range(0, 1)));
    offer_request(REQ_ALLOC, 32'h0, 1'b0, 1'b0);
    offer_request(REQ_ALLOC, 32'h0, 1'b1, 1'b1);
    offer_request(REQ_FREE, 32'h010F_F000, 1'b1, 1'b1);
    offer_request(REQ_FREE, 32'h0110_0000, 1'b1, 1'b1);
    offer_request(REQ_ALLOC, 32'h0, 1'b1, 1'b1);
    random_requests(200, VPBA_PAGE_COUNT - 1);
    gaps_on = 1'b0;
    random_requests(100, VPBA_PAGE_COUNT - 1);
    drain_results();

    if (fail_count == 0 && open_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
sv/vpba_pkg.sv
sv/virtual_page_bitmap_allocator_unit.sv
bench/vpba_allocation_checker.sv
bench/virtual_page_bitmap_allocator_unit_test.sv
